>>> rtl/lru_page_replacement_core_assert.svh
// Assertion macros for the LRU page replacement core.
`ifndef LRU_PAGE_REPLACEMENT_CORE_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_CORE_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define LRUPR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define LRUPR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/lrupr_pkg.sv
package lrupr_pkg;

    localparam int unsigned PAGE_W  = 16;
    localparam int unsigned CFG_W   = 4;
    localparam int unsigned SLOT_W  = 3;
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned ADDR_W  = 2;

    localparam logic [ADDR_W-1:0]  ADDR_FRAMES_IN_USE = 2'd0;
    localparam logic [CFG_W-1:0]   FRAMES_RESET       = 4'd3;
    localparam logic [COUNT_W-1:0] COUNT_MAX          = '1;

    typedef logic [PAGE_W-1:0] t_page;

    // Update command from the top level to one cell.
    typedef struct packed {
        logic step;   // an item is accepted this cycle
        logic load;   // this cell becomes most recent
        logic miss;   // the item missed in every cell
        logic clear;  // string ends or frame count rewritten
    } t_cell_upd;

    // Lookup status from one cell.
    typedef struct packed {
        logic match;  // valid and holds the referenced page
        logic valid;
        logic take;   // first empty active cell along the chain
    } t_cell_stat;

endpackage

>>> rtl/lrupr_cell.sv
module lrupr_cell #(
    parameter int unsigned RANK_W = 3
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  lrupr_pkg::t_page       i_page,
    input  logic                   i_active,
    input  logic                   i_empty_seen,
    output logic                   o_empty_seen,
    input  logic [RANK_W-1:0]      i_hit_rank,
    input  lrupr_pkg::t_cell_upd   i_upd,
    output lrupr_pkg::t_cell_stat  o_stat,
    output logic [RANK_W-1:0]      o_rank
);
    import lrupr_pkg::*;

    t_page             r_page;
    logic              r_valid;
    logic [RANK_W-1:0] r_rank;
    logic              w_empty;
    logic              w_age;

    assign w_empty      = i_active & ~r_valid;
    assign o_empty_seen = i_empty_seen | w_empty;

    assign o_stat.match = r_valid & (r_page == i_page);
    assign o_stat.valid = r_valid;
    assign o_stat.take  = w_empty & ~i_empty_seen;
    assign o_rank       = r_rank;

    // older by one step if more recent than the touched frame, or on any miss
    assign w_age = r_valid & (i_upd.miss | (r_rank < i_hit_rank));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else if (i_upd.clear) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else if (i_upd.step) begin
            if (i_upd.load) begin
                r_valid <= 1'b1;
                r_rank  <= '0;
            end else if (w_age) begin
                r_rank <= r_rank + RANK_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd.step && i_upd.load && i_upd.miss) begin
            r_page <= i_page;
        end
    end

endmodule

>>> rtl/lru_page_replacement_core.sv
// LRU page replacement core.
// Input channel (i_valid / o_ready) carries one page reference per item:
// i_page_number and i_last_in_string. Output channel (o_valid / i_ready)
// returns one result per item: o_hit, o_slot, o_fault_count, o_is_final.
// Frames are a row of cells; each compares the reference against its page
// in parallel and the first-empty search ripples along the row.
// o_valid rises in the cycle after acceptance. One item per cycle is sustained
// while i_ready stays high, set by the combinational compare and rank update in the cells.
// A result waits in the output register while the next item is accepted if
// i_ready is high in that cycle; while the receiver stalls with a result
// held, o_ready is low and no item is taken.
// frames_in_use is written through the APB port by a write to any address and
// read back at address 0; a write clears all frames and the fault count. An item
// flagged last clears them after its result is formed.
// Reset (synchronous, active low) empties all frames, zeroes the fault count
// and sets frames_in_use to 3. No clearing pass is needed.
`include "lru_page_replacement_core_assert.svh"

module lru_page_replacement_core #(
    parameter int unsigned MAX_FRAMES = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lrupr_pkg::ADDR_W-1:0]      paddr,
    input  logic [lrupr_pkg::DATA_W-1:0]      pwdata,
    output logic [lrupr_pkg::DATA_W-1:0]      prdata,
    output logic                              pready,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [lrupr_pkg::PAGE_W-1:0]      i_page_number,
    input  logic                              i_last_in_string,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_hit,
    output logic [lrupr_pkg::SLOT_W-1:0]      o_slot,
    output logic [lrupr_pkg::COUNT_W-1:0]     o_fault_count,
    output logic                              o_is_final
);
    import lrupr_pkg::*;

    localparam int unsigned RANK_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int unsigned NW     = $clog2(MAX_FRAMES + 1);

    logic [CFG_W-1:0]   r_frames;
    logic [COUNT_W-1:0] r_fault;
    logic               r_out_valid;
    logic               r_hit;
    logic [SLOT_W-1:0]  r_slot;
    logic [COUNT_W-1:0] r_fault_count;
    logic               r_is_final;

    logic [COUNT_W-1:0] n_fault;
    logic               w_accept;
    logic               w_cfg_wr;
    logic               w_clear;
    logic [NW-1:0]      w_frames;
    logic [RANK_W-1:0]  w_last_rank;
    logic [RANK_W-1:0]  w_hit_rank;
    logic [SLOT_W-1:0]  w_slot;
    logic               w_hit;

    t_cell_stat         w_stat [MAX_FRAMES];
    t_cell_upd          w_upd  [MAX_FRAMES];
    logic [RANK_W-1:0]  w_rank [MAX_FRAMES];
    logic [MAX_FRAMES:0]   w_seen;
    logic [MAX_FRAMES-1:0] w_active;
    logic [MAX_FRAMES-1:0] w_match;
    logic [MAX_FRAMES-1:0] w_take;
    logic [MAX_FRAMES-1:0] w_lru;
    logic [MAX_FRAMES-1:0] w_sel;

    assign o_ready  = ~r_out_valid | i_ready;
    assign w_accept = i_valid & o_ready;
    assign w_cfg_wr = psel & penable & pwrite;
    assign w_clear  = w_cfg_wr | (w_accept & i_last_in_string);

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_FRAMES_IN_USE) ?
                    {{(DATA_W - CFG_W){1'b0}}, r_frames} : '0;

    always_comb begin
        if (r_frames == '0) begin
            w_frames = NW'(1);
        end else if (int'(r_frames) > int'(MAX_FRAMES)) begin
            w_frames = NW'(MAX_FRAMES);
        end else begin
            w_frames = NW'(r_frames);
        end
    end

    assign w_last_rank = RANK_W'(w_frames - NW'(1));
    assign w_seen[0]   = 1'b0;

    for (genvar j = 0; j < MAX_FRAMES; j++) begin : g_cell
        localparam logic [NW-1:0] IDX = NW'(j);

        assign w_active[j] = IDX < w_frames;
        assign w_match[j]  = w_stat[j].match;
        assign w_take[j]   = w_stat[j].take;
        assign w_lru[j]    = w_stat[j].valid & w_active[j] & (w_rank[j] == w_last_rank);

        assign w_upd[j].step  = w_accept;
        assign w_upd[j].load  = w_sel[j];
        assign w_upd[j].miss  = ~w_hit;
        assign w_upd[j].clear = w_clear;

        lrupr_cell #(
            .RANK_W(RANK_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_page      (i_page_number),
            .i_active    (w_active[j]),
            .i_empty_seen(w_seen[j]),
            .o_empty_seen(w_seen[j+1]),
            .i_hit_rank  (w_hit_rank),
            .i_upd       (w_upd[j]),
            .o_stat      (w_stat[j]),
            .o_rank      (w_rank[j])
        );
    end

    assign w_hit = |w_match;
    assign w_sel = w_hit ? w_match : (w_seen[MAX_FRAMES] ? w_take : w_lru);

    always_comb begin
        w_hit_rank = '0;
        w_slot     = '0;
        for (int j = 0; j < MAX_FRAMES; j++) begin
            if (w_match[j]) begin
                w_hit_rank = w_hit_rank | w_rank[j];
            end
            if (w_sel[j]) begin
                w_slot = w_slot | SLOT_W'(j);
            end
        end
    end

    assign n_fault = (!w_hit && (r_fault != COUNT_MAX)) ? r_fault + COUNT_W'(1) : r_fault;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames <= FRAMES_RESET;
        end else if (w_cfg_wr) begin
            r_frames <= pwdata[CFG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault <= '0;
        end else if (w_cfg_wr) begin
            r_fault <= '0;
        end else if (w_accept) begin
            r_fault <= i_last_in_string ? '0 : n_fault;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hit         <= w_hit;
            r_slot        <= w_slot;
            r_fault_count <= n_fault;
            r_is_final    <= i_last_in_string;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_hit         = r_hit;
    assign o_slot        = r_slot;
    assign o_fault_count = r_fault_count;
    assign o_is_final    = r_is_final;

    `LRUPR_ASSERT_IMP(a_one_target, w_accept, $onehot(w_sel), "item has no single target frame")
    `LRUPR_ASSERT_IMP(a_single_match, 1'b1, $onehot0(w_match), "page resident in two frames")
    `LRUPR_ASSERT_NXT(a_result_follows, w_accept, r_out_valid, "accepted item left no result")
    `LRUPR_ASSERT_IMP(a_fault_counted, r_out_valid && !r_hit, r_fault_count != '0, "miss not counted")

endmodule

>>> tb/lru_page_replacement_core_tb.sv
`timescale 1ns / 100ps

module lru_page_replacement_core_tb;
    import lrupr_pkg::*;

    localparam int FRAME_SLOTS = 8;

    typedef struct {
        logic [PAGE_W-1:0] page;
        logic              last;
    } t_page_ref;

    typedef struct {
        logic               hit;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] faults;
        logic               final_ref;
    } t_lru_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [PAGE_W-1:0] i_page_number = '0;
    logic              i_last_in_string = 1'b0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic              o_hit;
    logic [SLOT_W-1:0] o_slot;
    logic [COUNT_W-1:0] o_fault_count;
    logic              o_is_final;

    lru_page_replacement_core #(.MAX_FRAMES(FRAME_SLOTS)) dut (.*);

    always #6 i_clk = ~i_clk;

    // predictor state
    logic [PAGE_W-1:0]  frame_page [FRAME_SLOTS];
    logic               frame_used [FRAME_SLOTS];
    int                 frame_rank [FRAME_SLOTS];
    logic [COUNT_W-1:0] fault_total;
    logic [CFG_W-1:0]   cfg_frames = FRAMES_RESET;

    t_page_ref   page_refs[$];
    t_lru_result expected_results[$];
    t_page_ref   next_ref;
    t_lru_result want;
    int          errors = 0;
    int          refs_taken = 0;
    bit          calm = 1'b0;
    int          src_gap = 0;
    int          sink_gap = 0;
    int          hold_cnt = 0;
    bit          hold_done = 1'b0;

    function automatic void clear_frames();
        for (int j = 0; j < FRAME_SLOTS; j++) begin
            frame_page[j] = '0;
            frame_used[j] = 1'b0;
            frame_rank[j] = 0;
        end
        fault_total = '0;
    endfunction

    function automatic t_lru_result lru_reference(logic [PAGE_W-1:0] page, logic last);
        t_lru_result r;
        int  n, f, lim;
        bit  found, empty;
        n = (cfg_frames == 0) ? 1 : ((cfg_frames > FRAME_SLOTS) ? FRAME_SLOTS : cfg_frames);
        found = 1'b0;
        f = 0;
        for (int j = 0; j < n; j++)
            if (!found && frame_used[j] && frame_page[j] == page) begin
                found = 1'b1;
                f = j;
            end
        if (found) begin
            lim = frame_rank[f];
        end else begin
            lim = 256;
            empty = 1'b0;
            for (int j = 0; j < n; j++)
                if (!empty && !frame_used[j]) begin
                    empty = 1'b1;
                    f = j;
                end
            if (!empty) begin
                f = 0;
                for (int j = 1; j < n; j++)
                    if (frame_rank[j] > frame_rank[f]) f = j;
            end
            frame_page[f] = page;
            frame_used[f] = 1'b1;
            if (fault_total != COUNT_MAX) fault_total++;
        end
        for (int j = 0; j < n; j++)
            if (j != f && frame_used[j] && frame_rank[j] < lim && frame_rank[j] < 255)
                frame_rank[j]++;
        frame_rank[f] = 0;
        r.hit = found;
        r.slot = 3'(f);
        r.faults = fault_total;
        r.final_ref = last;
        if (last) clear_frames();
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                i_valid <= 1'b0;
            end else if (page_refs.size() > 0) begin
                next_ref = page_refs.pop_front();
                i_valid <= 1'b1;
                i_page_number <= next_ref.page;
                i_last_in_string <= next_ref.last;
                if (!calm && $urandom_range(0, 5) == 0) src_gap <= $urandom_range(1, 11);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (!hold_done && refs_taken >= 200) begin
            hold_done <= 1'b1;
            hold_cnt <= 60;
            i_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if (!calm && $urandom_range(0, 5) == 0) sink_gap <= $urandom_range(1, 11);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                expected_results.push_back(lru_reference(i_page_number, i_last_in_string));
                refs_taken <= refs_taken + 1;
            end
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual hit=%0b slot=%0d",
                             $time, o_hit, o_slot);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("hit", want.hit, o_hit);
                    check_field("slot", want.slot, o_slot);
                    check_field("fault_count", want.faults, o_fault_count);
                    check_field("is_final", want.final_ref, o_is_final);
                end
            end
        end
    end

    task automatic queue_ref(logic [PAGE_W-1:0] page, logic last);
        t_page_ref r;
        r.page = page;
        r.last = last;
        page_refs.push_back(r);
    endtask

    task automatic wait_idle();
        do begin
            @(posedge i_clk);
            #1;
        end while (page_refs.size() != 0 || i_valid || expected_results.size() != 0);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_frames(logic [CFG_W-1:0] nib);
        logic [DATA_W-1:0] v;
        v = $urandom();
        v[CFG_W-1:0] = nib;
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_FRAMES_IN_USE;
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        cfg_frames = nib;
        clear_frames();
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field("frames_in_use readback", 32'(nib), prdata);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic queue_random_string_mix(int count);
        logic [PAGE_W-1:0] base;
        int span;
        span = (cfg_frames == 0) ? 3 : cfg_frames + 2;
        base = $urandom();
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 6) == 0)
                queue_ref($urandom(), $urandom_range(0, 14) == 0);
            else if ($urandom_range(0, 14) == 0) begin
                queue_ref(base + $urandom_range(0, span), 1'b1);
                base = $urandom();
            end else
                queue_ref(base + $urandom_range(0, span), 1'b0);
        end
    endtask

    initial begin
        logic [CFG_W-1:0] cfg_list [10] = '{4'd8, 4'd1, 4'd2, 4'd5, 4'd0,
                                             4'd4, 4'd7, 4'd6, 4'd15, 4'd3};
        clear_frames();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // three frames out of reset: fills, hits, evictions, string end
        queue_ref(16'h0000, 1'b0);
        queue_ref(16'hFFFF, 1'b0);
        queue_ref(16'h0000, 1'b0);
        queue_ref(16'h8001, 1'b0);
        queue_ref(16'h1234, 1'b0);
        queue_ref(16'h0000, 1'b0);
        queue_ref(16'hFFFF, 1'b0);
        queue_ref(16'h5555, 1'b1);
        queue_ref(16'hAAAA, 1'b0);
        queue_ref(16'h0001, 1'b0);
        wait_idle();
        // mid-string write; zero frames acts as one
        write_frames(4'd0);
        queue_ref(16'h0007, 1'b0);
        queue_ref(16'h0007, 1'b0);
        queue_ref(16'h0009, 1'b0);
        queue_ref(16'h0007, 1'b1);
        wait_idle();
        // above max clamps to eight
        write_frames(4'd15);
        for (int p = 1; p <= 8; p++) queue_ref(16'(p), 1'b0);
        queue_ref(16'h0001, 1'b0);
        queue_ref(16'h0009, 1'b0);
        queue_ref(16'hFFFF, 1'b1);
        wait_idle();

        for (int ph = 0; ph < 10; ph++) begin
            write_frames(cfg_list[ph]);
            if (ph == 9) calm = 1'b1;
            queue_random_string_mix(70);
            wait_idle();
        end

        repeat (5) @(posedge i_clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #3000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
